/* sv/tof_pkg.sv */
// ----------------------------------------------------------------------------
// tof_pkg
// Types, constants and arithmetic helpers shared by the third-order IIR filter.
// ----------------------------------------------------------------------------
package tof_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 32;
	localparam int OUT_WIDTH    = 48;
	localparam int NUM_COEF     = 6;
	localparam int IDX_WIDTH    = 3;

	// Q4.28 coefficients; x is taken as Q.16 so the x shift is 28 - 16
	localparam int FRAC_SHIFT   = 28;
	localparam int X_SHIFT      = FRAC_SHIFT - 16;
	localparam int YL_WIDTH     = 16;
	localparam int YH_WIDTH     = OUT_WIDTH - YL_WIDTH;

	localparam int XPROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int XTERM_WIDTH  = XPROD_WIDTH - X_SHIFT;
	localparam int YPROD_WIDTH  = OUT_WIDTH + COEF_WIDTH;
	localparam int YTERM_WIDTH  = YPROD_WIDTH - FRAC_SHIFT;
	localparam int ACC_WIDTH    = YTERM_WIDTH + 3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [OUT_WIDTH-1:0]    out_t;
	typedef logic signed [XTERM_WIDTH-1:0]  xterm_t;
	typedef logic signed [YTERM_WIDTH-1:0]  yterm_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic [IDX_WIDTH-1:0]           reg_idx_t;

	typedef coef_t coef_arr_t [NUM_COEF];

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_COEF_X1 = 3'd0,
		REG_COEF_X2 = 3'd1,
		REG_COEF_X3 = 3'd2,
		REG_COEF_Y1 = 3'd3,
		REG_COEF_Y2 = 3'd4,
		REG_COEF_Y3 = 3'd5
	} reg_sel_t;

	localparam coef_t COEF_RESET [NUM_COEF] = '{
		32'sd40453,
		32'sd152337,
		32'sd35863,
		32'sd742224036,
		-32'sd685047284,
		32'sd211151331
	};

	localparam acc_t OUT_MAX = acc_t'({1'b0, {(OUT_WIDTH-1){1'b1}}});
	localparam acc_t OUT_MIN = acc_t'($signed({1'b1, {(OUT_WIDTH-1){1'b0}}}));

	// one result beat handed from the datapath to the output buffer
	typedef struct packed {
		logic valid;
		out_t data;
	} result_beat_t;

	// floor(x * c / 2^12)
	function automatic xterm_t mul_x(input sample_t x, input coef_t c);
		logic signed [XPROD_WIDTH-1:0] p;
		p = x * c;
		return p[XPROD_WIDTH-1:X_SHIFT];
	endfunction

	// floor(y * c / 2^28), split into a 32x32 and a 17x32 partial product
	function automatic yterm_t mul_y(input out_t y, input coef_t c);
		logic signed [YH_WIDTH-1:0]             yh;
		logic signed [YL_WIDTH:0]               yl;
		logic signed [YH_WIDTH+COEF_WIDTH-1:0]  ph;
		logic signed [YL_WIDTH+COEF_WIDTH:0]    pl;
		logic signed [YPROD_WIDTH-1:0]          full;
		yh   = y[OUT_WIDTH-1:YL_WIDTH];
		yl   = {1'b0, y[YL_WIDTH-1:0]};
		ph   = yh * c;
		pl   = yl * c;
		full = $signed({ph, {YL_WIDTH{1'b0}}}) + YPROD_WIDTH'(pl);
		return full[YPROD_WIDTH-1:FRAC_SHIFT];
	endfunction

	function automatic out_t saturate(input acc_t a);
		out_t r;
		if (a > OUT_MAX) begin
			r = OUT_MAX[OUT_WIDTH-1:0];
		end else if (a < OUT_MIN) begin
			r = OUT_MIN[OUT_WIDTH-1:0];
		end else begin
			r = a[OUT_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/tof_ifs.sv */
// ----------------------------------------------------------------------------
// tof stream interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface tof_sample_if;
	import tof_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tof_result_if;
	import tof_pkg::*;

	logic valid;
	logic ready;
	out_t filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

/* sv/third_order_iir_filter.sv */
// ----------------------------------------------------------------------------
// third_order_iir_filter
// Third-order recursive filter over signed sensor samples, Q32.16 output.
// ----------------------------------------------------------------------------
// Takes one sample per clock and gives one filtered beat per sample, in the
// cycle after acceptance when the output side is ready. Each result is
// c1*x[n-1]+c2*x[n-2]+c3*x[n-3]+d1*y[n-1]+d2*y[n-2]+d3*y[n-3] with Q4.28
// coefficients, products floored at bit 28 and the sum saturated to 48 bits;
// the new sample only enters history. The feedback path (six multiplies, the
// sum and the clamp, from history flops back into history flops) holds no
// register and sets the clock. A two-entry output buffer keeps the input open
// while one result waits; a second waiting result stalls the input. Coefficients
// reset to a Bessel low-pass; the user must write them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module third_order_iir_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  tof_pkg::reg_idx_t wr_index,
	input  tof_pkg::coef_t    wr_data,
	tof_sample_if.sink        sample_ch,
	tof_result_if.source      result_ch
);
	import tof_pkg::*;

	coef_arr_t    coef;
	result_beat_t beat;
	logic         buf_ready;
	logic         accept;

	assign sample_ch.ready = buf_ready;
	assign accept          = sample_ch.valid && buf_ready;

	tof_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef)
	);

	tof_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample_ch.sample),
		.coef   (coef),
		.beat   (beat)
	);

	tof_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (beat),
		.ready     (buf_ready),
		.result_ch (result_ch)
	);

	// every accepted sample shows up as a pending result next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.valid && sample_ch.ready |=> result_ch.valid)
		else $error("accepted sample produced no pending result");

	// input only stalls while results are waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ch.ready |-> result_ch.valid)
		else $error("input stalled with no pending result");

	// input closes only after the output side held off a beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ch.ready) |-> $past(result_ch.valid && !result_ch.ready))
		else $error("input stalled without output backpressure");

endmodule

/* sv/tof_coef_regs.sv */
// ----------------------------------------------------------------------------
// tof_coef_regs
// Coefficient register file; writes past the last register are dropped.
// ----------------------------------------------------------------------------
module tof_coef_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  tof_pkg::reg_idx_t  wr_index,
	input  tof_pkg::coef_t     wr_data,
	output tof_pkg::coef_arr_t coef
);
	import tof_pkg::*;

	coef_arr_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_COEF_X1: coef_q[0] <= wr_data;
				REG_COEF_X2: coef_q[1] <= wr_data;
				REG_COEF_X3: coef_q[2] <= wr_data;
				REG_COEF_Y1: coef_q[3] <= wr_data;
				REG_COEF_Y2: coef_q[4] <= wr_data;
				REG_COEF_Y3: coef_q[5] <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

/* sv/tof_datapath.sv */
// ----------------------------------------------------------------------------
// tof_datapath
// Sample/output history and the six-term multiply-accumulate with saturation.
// ----------------------------------------------------------------------------
module tof_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  tof_pkg::sample_t      sample,
	input  tof_pkg::coef_arr_t    coef,
	output tof_pkg::result_beat_t beat
);
	import tof_pkg::*;

	sample_t x_hist_q [3];
	out_t    y_hist_q [3];

	acc_t acc;
	out_t y_next;

	// current sample has no weight: the result comes from history alone
	always_comb begin
		acc = acc_t'(mul_x(x_hist_q[0], coef[0]))
		    + acc_t'(mul_x(x_hist_q[1], coef[1]))
		    + acc_t'(mul_x(x_hist_q[2], coef[2]))
		    + acc_t'(mul_y(y_hist_q[0], coef[3]))
		    + acc_t'(mul_y(y_hist_q[1], coef[4]))
		    + acc_t'(mul_y(y_hist_q[2], coef[5]));
		y_next = saturate(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else if (accept) begin
			x_hist_q[2] <= x_hist_q[1];
			x_hist_q[1] <= x_hist_q[0];
			x_hist_q[0] <= sample;
			y_hist_q[2] <= y_hist_q[1];
			y_hist_q[1] <= y_hist_q[0];
			y_hist_q[0] <= y_next;
		end
	end

	assign beat.valid = accept;
	assign beat.data  = y_next;

endmodule

/* sv/tof_out_buf.sv */
// ----------------------------------------------------------------------------
// tof_out_buf
// Two-entry output register with skid slot; ready comes from a flop.
// ----------------------------------------------------------------------------
module tof_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tof_pkg::result_beat_t push,
	output logic                  ready,
	tof_result_if.source          result_ch
);
	import tof_pkg::*;

	logic head_vld_q;
	logic skid_vld_q;
	out_t head_q;
	out_t skid_q;
	logic pop;

	assign pop = head_vld_q && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			// a push never coincides with a full skid slot
			head_vld_q <= skid_vld_q || push.valid;
			skid_vld_q <= 1'b0;
		end else if (push.valid) begin
			if (head_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				head_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= skid_vld_q ? skid_q : push.data;
		end else if (push.valid) begin
			if (head_vld_q) begin
				skid_q <= push.data;
			end else begin
				head_q <= push.data;
			end
		end
	end

	assign ready              = !skid_vld_q;
	assign result_ch.valid    = head_vld_q;
	assign result_ch.filtered = head_q;

endmodule

/* verif/third_order_iir_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_order_iir_filter_tb
// Self-checking bench for the third-order recursive sample filter.
// ----------------------------------------------------------------------------
// Streams signed samples into the filter with random gaps on both channels.
// Coefficients are reloaded between phases with the pipe drained. Each
// filtered beat is checked against a bit-accurate model of the recursion kept
// here, or against the value typed into the table. The run starts with a short
// directed table: field extremes, coefficient extremes, all-zero coefficients
// and writes to unused register indexes. Random phases follow with Bessel,
// damped, wild and corner coefficient sets.
// ----------------------------------------------------------------------------
module third_order_iir_filter_tb;
	import tof_pkg::*;

	localparam int NUM_TAPS        = 3;
	localparam int Q_IN            = 16;
	localparam int Q_COEF          = 28;
	localparam int DAMP_SPAN       = 1 << 26;
	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int N_DIR           = 22;

	typedef logic signed [95:0] wide_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
	localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
	localparam out_t    FILT_MAX   = {1'b0, {(OUT_WIDTH-1){1'b1}}};
	localparam wide_t   SUM_MAX    = (wide_t'(1) <<< (OUT_WIDTH-1)) - wide_t'(1);
	localparam wide_t   SUM_MIN    = -(wide_t'(1) <<< (OUT_WIDTH-1));

	// indexes past the last coefficient, writes there must be dropped
	localparam reg_idx_t REG_SPARE_LO = reg_idx_t'(NUM_COEF);
	localparam reg_idx_t REG_SPARE_HI = '1;

	localparam reg_sel_t COEF_REG [NUM_COEF] = '{
		REG_COEF_X1, REG_COEF_X2, REG_COEF_X3, REG_COEF_Y1, REG_COEF_Y2, REG_COEF_Y3
	};

	typedef enum logic [3:0] {
		MIX_BESSEL,
		MIX_DAMPED,
		MIX_WILD,
		MIX_CORNER,
		MIX_ALL_MAX,
		MIX_ALL_MIN,
		MIX_ZERO,
		MIX_SPARE,
		MIX_NONE
	} coef_mix_t;

	localparam coef_mix_t RANDOM_MIXES [4] = '{MIX_BESSEL, MIX_DAMPED, MIX_WILD, MIX_CORNER};

	typedef struct packed {
		coef_mix_t mix;
		sample_t   sample;
		logic      typed_in;
		out_t      filtered;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// reset coefficients; first beat sees empty history
		'{MIX_NONE,    '0,             1'b1, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MIN,     1'b0, '0},
		'{MIX_NONE,    sample_t'(1),   1'b0, '0},
		'{MIX_NONE,    sample_t'(-1),  1'b0, '0},
		'{MIX_NONE,    '0,             1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MIN,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		// all weights at max: feedback runs into the upper clamp
		'{MIX_ALL_MAX, SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		// all weights at min: output swings between both clamps
		'{MIX_ALL_MIN, SAMPLE_MIN,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MIN,     1'b0, '0},
		'{MIX_NONE,    SAMPLE_MAX,     1'b0, '0},
		// zero weights give zero whatever the history
		'{MIX_ZERO,    SAMPLE_MAX,     1'b1, '0},
		'{MIX_NONE,    SAMPLE_MIN,     1'b1, '0},
		// junk to unused indexes leaves the zero weights alone
		'{MIX_SPARE,   SAMPLE_MAX,     1'b1, '0},
		'{MIX_NONE,    sample_t'(-1),  1'b1, '0}
	};

	logic     clk;
	logic     arst_n;
	logic     wr_en;
	reg_idx_t wr_index;
	coef_t    wr_data;

	tof_sample_if sample_ch ();
	tof_result_if result_ch ();

	third_order_iir_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// filter model state
	coef_t   coef   [NUM_COEF];
	sample_t x_hist [NUM_TAPS];
	out_t    y_hist [NUM_TAPS];

	out_t pending_filtered [$];
	logic idle_off;
	int   n_errors;
	int   n_samples;
	int   n_filtered;
	int   n_clamped;
	int   n_writes;
	int   n_settings;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// next output of the recursion; the new sample only enters history
	function automatic out_t filter_step(input sample_t s);
		wide_t acc;
		wide_t prod;
		out_t  y;
		acc = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			prod = x_hist[k] * coef[k];
			acc  = acc + ((prod <<< Q_IN) >>> Q_COEF);
			prod = y_hist[k] * coef[NUM_TAPS + k];
			acc  = acc + (prod >>> Q_COEF);
		end
		if (acc > SUM_MAX) begin
			y = FILT_MAX;
			n_clamped++;
		end else if (acc < SUM_MIN) begin
			y = ~FILT_MAX;
			n_clamped++;
		end else begin
			y = acc[OUT_WIDTH-1:0];
		end
		x_hist[2] = x_hist[1];
		x_hist[1] = x_hist[0];
		x_hist[0] = s;
		y_hist[2] = y_hist[1];
		y_hist[1] = y_hist[0];
		y_hist[0] = y;
		return y;
	endfunction

	task automatic send_sample(input sample_t s, input logic typed_in, input out_t typed_val);
		int   gap;
		out_t y;
		gap = idle_off ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(negedge clk); while (!sample_ch.ready);
		@(posedge clk);
		y = filter_step(s);
		pending_filtered.push_back(typed_in ? typed_val : y);
		n_samples++;
	endtask

	// hold off input until every outstanding beat is out
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (pending_filtered.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input coef_t v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		if (idx < NUM_COEF) coef[idx] = v;
		n_writes++;
	endtask

	task automatic load_coefs(input coef_mix_t mix, input logic spare);
		coef_t v;
		if (spare || mix == MIX_SPARE) begin
			write_reg(REG_SPARE_LO, coef_t'($urandom));
			write_reg(REG_SPARE_HI, coef_t'($urandom));
		end
		if (mix != MIX_SPARE) begin
			for (int k = 0; k < NUM_COEF; k++) begin
				case (mix)
					MIX_BESSEL: v = COEF_RESET[k];
					// feedback kept within +/-0.25 per tap so the loop stays stable
					MIX_DAMPED: v = (k < NUM_TAPS) ? coef_t'($urandom)
						: coef_t'($urandom_range(0, 2 * DAMP_SPAN - 1)) - coef_t'(DAMP_SPAN);
					MIX_WILD: v = coef_t'($urandom);
					MIX_CORNER: begin
						case ($urandom_range(0, 4))
							0: v = COEF_MAX;
							1: v = COEF_MIN;
							2: v = coef_t'(1);
							3: v = coef_t'(-1);
							default: v = '0;
						endcase
					end
					MIX_ALL_MAX: v = COEF_MAX;
					MIX_ALL_MIN: v = COEF_MIN;
					default: v = '0;
				endcase
				write_reg(COEF_REG[k], v);
			end
		end
		wr_en <= 1'b0;
		n_settings++;
	endtask

	initial begin : result_side
		int   stall;
		out_t got;
		out_t want;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			// ready is ours and held, so a valid seen here is a beat at the next edge
			do @(negedge clk); while (!result_ch.valid);
			got = result_ch.filtered;
			if (pending_filtered.size() == 0) begin
				$error("filtered: expected nothing, got %0d", got);
				n_errors++;
			end else begin
				want = pending_filtered.pop_front();
				if (got !== want) begin
					$error("filtered: expected %0d, got %0d", want, got);
					n_errors++;
				end
			end
			n_filtered++;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		sample_t   s;
		coef_mix_t mix;
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		idle_off         = 1'b0;
		n_errors         = 0;
		n_samples        = 0;
		n_filtered       = 0;
		n_clamped        = 0;
		n_writes         = 0;
		n_settings       = 0;
		for (int k = 0; k < NUM_COEF; k++) coef[k] = COEF_RESET[k];
		for (int k = 0; k < NUM_TAPS; k++) begin
			x_hist[k] = '0;
			y_hist[k] = '0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (DIR_ROWS[r].mix != MIX_NONE) begin
				wait_idle();
				load_coefs(DIR_ROWS[r].mix, 1'b0);
			end
			send_sample(DIR_ROWS[r].sample, DIR_ROWS[r].typed_in, DIR_ROWS[r].filtered);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			mix = (ph < 4) ? RANDOM_MIXES[ph] : RANDOM_MIXES[$urandom_range(0, 3)];
			load_coefs(mix, $urandom_range(0, 1));
			idle_off = (ph % 4 == 3);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: s = sample_t'($urandom);
					6, 7, 8: s = sample_t'($urandom_range(0, 512)) - sample_t'(256);
					default: begin
						case ($urandom_range(0, 3))
							0: s = SAMPLE_MAX;
							1: s = SAMPLE_MIN;
							2: s = sample_t'(-1);
							default: s = '0;
						endcase
					end
				endcase
				send_sample(s, 1'b0, '0);
				if ($urandom_range(0, 63) == 0) wait_idle();
			end
		end

		wait_idle();
		idle_off = 1'b0;
		repeat (8) @(posedge clk);
		if (pending_filtered.size() != 0) begin
			$error("filtered: %0d beats never arrived", pending_filtered.size());
			n_errors++;
		end

		$display("%0d samples in, %0d filtered beats out, %0d of them clamped",
			n_samples, n_filtered, n_clamped);
		$display("%0d coefficient loads over %0d register writes", n_settings, n_writes);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/tof_pkg.sv
sv/tof_ifs.sv
sv/tof_coef_regs.sv
sv/tof_datapath.sv
sv/tof_out_buf.sv
sv/third_order_iir_filter.sv
verif/third_order_iir_filter_tb.sv
